/* src/acm_pkg.sv */
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types, constants and helpers of the audio crosspoint mixer.
// ----------------------------------------------------------------------------
package acm_pkg;

    localparam int SAMPLE_W     = 24;
    localparam int MAX_CH       = 8;
    localparam int DEF_CHANNELS = 8;
    localparam int CNT_W        = 4;
    localparam int XP_W         = MAX_CH * MAX_CH;
    localparam int MASK_W       = MAX_CH;
    localparam int TDATA_W      = MAX_CH * SAMPLE_W;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 64;

    localparam logic [XP_W-1:0]  XP_RESET    = 64'h8040201008040201;
    localparam logic [CNT_W-1:0] COUNT_RESET = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_XPOINT   = 8'd0,
        REG_IN_MUTE  = 8'd1,
        REG_OUT_MUTE = 8'd2,
        REG_ACT_IN   = 8'd3,
        REG_ACT_OUT  = 8'd4
    } cfg_reg_t;

    // live settings, counts already clamped to the built channel count
    typedef struct packed {
        logic [XP_W-1:0]   xpoint;
        logic [MASK_W-1:0] in_mute;
        logic [MASK_W-1:0] out_mute;
        logic [CNT_W-1:0]  nin;
        logic [CNT_W-1:0]  nout;
    } acm_cfg_t;

    function automatic logic [CNT_W-1:0] clamp_count(
        input logic [CNT_W-1:0] c,
        input logic [CNT_W-1:0] lim
    );
        return (c > lim) ? lim : c;
    endfunction

endpackage

/* src/acm_cfg.sv */
// ----------------------------------------------------------------------------
// acm_cfg
// Configuration register file: crosspoint map, mutes and channel counts.
// ----------------------------------------------------------------------------
module acm_cfg #(
    parameter int CHANNELS = acm_pkg::DEF_CHANNELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [acm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [acm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output acm_pkg::acm_cfg_t               cfg
);
    import acm_pkg::*;

    localparam logic [CNT_W-1:0] CH_CNT = CNT_W'(CHANNELS);

    logic [XP_W-1:0]   xpoint_reg;
    logic [MASK_W-1:0] in_mute_reg;
    logic [MASK_W-1:0] out_mute_reg;
    logic [CNT_W-1:0]  act_in_reg;
    logic [CNT_W-1:0]  act_out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xpoint_reg   <= XP_RESET;
            in_mute_reg  <= '0;
            out_mute_reg <= '0;
            act_in_reg   <= COUNT_RESET;
            act_out_reg  <= COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_XPOINT:   xpoint_reg   <= cfg_data[XP_W-1:0];
                REG_IN_MUTE:  in_mute_reg  <= cfg_data[MASK_W-1:0];
                REG_OUT_MUTE: out_mute_reg <= cfg_data[MASK_W-1:0];
                REG_ACT_IN:   act_in_reg   <= cfg_data[CNT_W-1:0];
                REG_ACT_OUT:  act_out_reg  <= cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        cfg.xpoint   = xpoint_reg;
        cfg.in_mute  = in_mute_reg;
        cfg.out_mute = out_mute_reg;
        cfg.nin      = clamp_count(act_in_reg, CH_CNT);
        cfg.nout     = clamp_count(act_out_reg, CH_CNT);
    end

endmodule

/* src/acm_lane.sv */
// ----------------------------------------------------------------------------
// acm_lane
// One output channel: saturating sum of routed inputs; silence when inactive.
// ----------------------------------------------------------------------------
module acm_lane #(
    parameter int CHANNELS = acm_pkg::DEF_CHANNELS
) (
    input  logic                                clk,
    input  logic                                load,
    input  logic signed [acm_pkg::SAMPLE_W-1:0] samples [CHANNELS],
    input  logic [CHANNELS-1:0]                 route,
    input  logic                                active,
    output logic signed [acm_pkg::SAMPLE_W-1:0] mix
);
    import acm_pkg::*;

    localparam int SUM_W = SAMPLE_W + $clog2(CHANNELS + 1);
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    logic signed [SUM_W-1:0]    acc;
    logic signed [SAMPLE_W-1:0] mix_next;
    logic signed [SAMPLE_W-1:0] mix_reg;

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (route[i])
                acc = acc + SUM_W'(samples[i]);
        end
        if (!active)
            mix_next = '0;
        else if (acc > SAT_HI)
            mix_next = SAT_HI[SAMPLE_W-1:0];
        else if (acc < SAT_LO)
            mix_next = SAT_LO[SAMPLE_W-1:0];
        else
            mix_next = acc[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load)
            mix_reg <= mix_next;
    end

    assign mix = mix_reg;

endmodule

/* src/audio_crosspoint_mixer.sv */
// input frames pass the gate stage register, then the mix lane registers
// throughput: one frame per clock unless the output stalls; all output lanes sum
// in parallel; a stalled output still lets one more frame enter the gate stage
// reset: crosspoint map back to input i -> output i, no mutes, all channels active,
// pipeline emptied
// ----------------------------------------------------------------------------
// audio_crosspoint_mixer
// Eight-channel crosspoint mixer: gated inputs, one saturating sum per output.
// ----------------------------------------------------------------------------
module audio_crosspoint_mixer #(
    parameter int CHANNELS = acm_pkg::DEF_CHANNELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // in_0 .. in_7, 24 bits each, in_0 lowest
    input  logic [acm_pkg::TDATA_W-1:0]     s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // out_0 .. out_7, 24 bits each, out_0 lowest
    output logic [acm_pkg::TDATA_W-1:0]     m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [acm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [acm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import acm_pkg::*;

    localparam logic [CNT_W-1:0] CH_CNT = CNT_W'(CHANNELS);

    acm_cfg_t cfg;

    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg [CHANNELS];
    logic                       out_valid_reg;
    logic                       s1_adv;
    logic                       in_take;
    logic signed [SAMPLE_W-1:0] lane_mix [CHANNELS];

    acm_cfg #(
        .CHANNELS (CHANNELS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign s1_adv   = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                s1_valid_reg <= s_tvalid;
            if (s1_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // gate stage: inactive or muted inputs become silence
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if ((CNT_W'(i) < cfg.nin) && !cfg.in_mute[i])
                    s1_sample_reg[i] <= s_tdata[i*SAMPLE_W +: SAMPLE_W];
                else
                    s1_sample_reg[i] <= '0;
            end
        end
    end

    for (genvar o = 0; o < MAX_CH; o++)
    begin : g_out
        if (o < CHANNELS)
        begin : g_lane
            logic [CHANNELS-1:0] route;

            for (genvar i = 0; i < CHANNELS; i++)
            begin : g_route
                assign route[i] = cfg.xpoint[i*MAX_CH + o];
            end

            acm_lane #(
                .CHANNELS (CHANNELS)
            ) u_lane (
                .clk     (clk),
                .load    (s1_adv),
                .samples (s1_sample_reg),
                .route   (route),
                .active  ((CNT_W'(o) < cfg.nout) && !cfg.out_mute[o]),
                .mix     (lane_mix[o])
            );

            assign m_tdata[o*SAMPLE_W +: SAMPLE_W] = lane_mix[o];
        end
        else
        begin : g_unused
            assign m_tdata[o*SAMPLE_W +: SAMPLE_W] = '0;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_take_fills_gate: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> s1_valid_reg)
        else $error("accepted frame missing from gate stage");

    a_gate_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg)
        else $error("gate stage dropped a stalled frame");

    a_gate_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_adv |=> out_valid_reg)
        else $error("mixed frame not presented");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> s_tready)
        else $error("empty gate stage refuses input");

    a_count_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.nin <= CH_CNT) && (cfg.nout <= CH_CNT))
        else $error("channel count beyond built lanes");
`endif

endmodule
